// ===== rtl/core/qrhc_pkg.sv =====
// Package for the queue resource hazard checker.
// Holds table sizing constants, the entry layout and the controller state type.
// No dependencies.
package qrhc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ID_WIDTH    = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        MODE_CLEAR    = 2'd0,
        MODE_GRAPHICS = 2'd1,
        MODE_COMPUTE  = 2'd2,
        MODE_COPY     = 2'd3
    } mode_t;

    typedef struct packed {
        logic rd;
        logic wr;
        logic gfx;
        logic cmp;
    } marks_t;

    typedef struct packed {
        logic [ID_WIDTH-1:0] id;
        marks_t              marks;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   bad;
        marks_t marks;
    } verdict_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

endpackage

// ===== rtl/core/qrhc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
module qrhc_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 20,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/qrhc_rules.sv =====
// Hazard rules for one access against the marks of its table entry.
// Produces the conflict verdict and the updated marks. Uses qrhc_pkg.
module qrhc_rules (
    input  qrhc_pkg::mode_t    mode,
    input  logic               wr,
    input  logic               shareable,
    input  qrhc_pkg::marks_t   marks,
    output qrhc_pkg::verdict_t verdict
);

    always_comb
    begin
        verdict.bad   = marks.wr;
        verdict.marks = marks;
        if (mode == qrhc_pkg::MODE_COMPUTE && marks.gfx && !shareable)
        begin
            verdict.bad = 1'b1;
        end
        if (mode == qrhc_pkg::MODE_COPY && (marks.gfx || marks.cmp) && !shareable)
        begin
            verdict.bad = 1'b1;
        end
        if (wr && marks.rd)
        begin
            verdict.bad = 1'b1;
        end
        // A graphics or compute access leaves its queue mark; copy leaves none.
        if (mode == qrhc_pkg::MODE_GRAPHICS)
        begin
            verdict.marks.gfx = 1'b1;
        end
        if (mode == qrhc_pkg::MODE_COMPUTE)
        begin
            verdict.marks.cmp = 1'b1;
        end
        if (wr)
        begin
            verdict.marks.wr = 1'b1;
        end
        else
        begin
            verdict.marks.rd = 1'b1;
        end
    end

endmodule

// ===== rtl/core/queue_resource_hazard_checker_core.sv =====
// Top level of the queue resource hazard checker.
// Uses qrhc_pkg, qrhc_ram (entry table) and qrhc_rules (hazard rules).
//
// Usage: a request is accepted at a rising edge where start is high and busy
// is low; its fields are mode, resource_id, is_write, is_buffer and
// allow_shared. Each request yields exactly one result: done is high for one
// cycle and no_conflict / table_full carry the bundle status in that cycle.
// The receiver cannot stall; it must take the result while done is high.
//
// The resource table lives in a synchronous RAM with a registered read. Entries
// are filled in order, so the fill count tells which entries are live and a
// clear request simply resets the count; no clearing pass is needed.
// Lookup is a linear scan of the live entries, one RAM read per cycle.
//
// A clear request, or any request once a conflict has frozen the bundle,
// returns its result in the cycle after acceptance. An access scans the
// live entries in order and returns when it hits an entry or has passed
// the last live one; busy stays high during the scan. A new request may be
// accepted in the cycle in which done is shown.
//
// Reset clears the fill count and both sticky flags: the table is empty,
// no_conflict reads 1 and table_full reads 0.
module queue_resource_hazard_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [15:0] resource_id,
    input  logic        is_write,
    input  logic        is_buffer,
    input  logic        allow_shared,
    output logic        done,
    output logic        no_conflict,
    output logic        table_full
);

    qrhc_pkg::state_t                 state_reg, state_next;
    logic [qrhc_pkg::IDX_W-1:0]       addr_reg, addr_next;
    logic [qrhc_pkg::CNT_W-1:0]       count_reg, count_next;
    logic                             conflict_reg, conflict_next;
    logic                             overflow_reg, overflow_next;
    logic                             done_reg, done_next;

    // Fields of the request in flight; payload, no reset needed.
    qrhc_pkg::mode_t                  mode_reg, mode_next;
    logic [qrhc_pkg::ID_WIDTH-1:0]    id_reg, id_next;
    logic                             wr_reg, wr_next;
    logic                             share_reg, share_next;

    logic                             ram_we;
    logic [qrhc_pkg::IDX_W-1:0]       ram_waddr;
    qrhc_pkg::entry_t                 ram_wdata;
    logic [qrhc_pkg::IDX_W-1:0]       ram_raddr;
    logic [qrhc_pkg::ENTRY_W-1:0]     ram_rdata_raw;
    qrhc_pkg::entry_t                 ram_rdata;

    logic                             hit;
    logic                             last_entry;
    logic [qrhc_pkg::CNT_W-1:0]       addr_plus;
    qrhc_pkg::marks_t                 rule_marks;
    qrhc_pkg::verdict_t               verdict;

    assign ram_rdata = qrhc_pkg::entry_t'(ram_rdata_raw);

    qrhc_ram #(
        .DEPTH (qrhc_pkg::TABLE_DEPTH),
        .WIDTH (qrhc_pkg::ENTRY_W)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_raw)
    );

    // The entry read during a scan is the one at addr_reg. A miss is checked
    // against empty marks, which can never raise a conflict.
    assign hit        = (state_reg == qrhc_pkg::ST_SCAN) && (ram_rdata.id == id_reg);
    assign addr_plus  = qrhc_pkg::CNT_W'(addr_reg) + qrhc_pkg::CNT_W'(1);
    assign last_entry = (addr_plus == count_reg);
    assign rule_marks = hit ? ram_rdata.marks : '0;

    qrhc_rules u_rules (
        .mode      (mode_reg),
        .wr        (wr_reg),
        .shareable (share_reg),
        .marks     (rule_marks),
        .verdict   (verdict)
    );

    // Reads are issued ahead of use: entry 0 while idle, the next entry while scanning.
    // Writes happen only in the final scan cycle or when an empty table takes its
    // first entry, so the next request never reads an entry still being updated.
    assign ram_raddr = (state_reg == qrhc_pkg::ST_SCAN) ? addr_plus[qrhc_pkg::IDX_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= qrhc_pkg::ST_IDLE;
            addr_reg     <= '0;
            count_reg    <= '0;
            conflict_reg <= 1'b0;
            overflow_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            count_reg    <= count_next;
            conflict_reg <= conflict_next;
            overflow_reg <= overflow_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        id_reg    <= id_next;
        wr_reg    <= wr_next;
        share_reg <= share_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        count_next    = count_reg;
        conflict_next = conflict_reg;
        overflow_next = overflow_reg;
        done_next     = 1'b0;
        mode_next     = mode_reg;
        id_next       = id_reg;
        wr_next       = wr_reg;
        share_next    = share_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '{id: id_reg, marks: verdict.marks};

        unique case (state_reg)
            qrhc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    mode_next  = qrhc_pkg::mode_t'(mode);
                    id_next    = resource_id[qrhc_pkg::ID_WIDTH-1:0];
                    wr_next    = is_write;
                    share_next = is_buffer || allow_shared;
                    addr_next  = '0;
                    if (qrhc_pkg::mode_t'(mode) == qrhc_pkg::MODE_CLEAR)
                    begin
                        count_next    = '0;
                        conflict_next = 1'b0;
                        overflow_next = 1'b0;
                        done_next     = 1'b1;
                    end
                    else if (conflict_reg)
                    begin
                        // Bundle is frozen after a conflict.
                        done_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        // Empty table: the new resource takes entry 0 at once.
                        // Its marks follow from an empty entry, so no conflict.
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = '{
                            id: resource_id[qrhc_pkg::ID_WIDTH-1:0],
                            marks: '{
                                rd:  !is_write,
                                wr:  is_write,
                                gfx: qrhc_pkg::mode_t'(mode) == qrhc_pkg::MODE_GRAPHICS,
                                cmp: qrhc_pkg::mode_t'(mode) == qrhc_pkg::MODE_COMPUTE
                            }
                        };
                        count_next = qrhc_pkg::CNT_W'(1);
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = qrhc_pkg::ST_SCAN;
                    end
                end
            end

            qrhc_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    if (verdict.bad)
                    begin
                        conflict_next = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = addr_reg;
                    end
                    done_next  = 1'b1;
                    state_next = qrhc_pkg::ST_IDLE;
                end
                else if (last_entry)
                begin
                    if (count_reg == qrhc_pkg::CNT_W'(qrhc_pkg::TABLE_DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[qrhc_pkg::IDX_W-1:0];
                        count_next = count_reg + qrhc_pkg::CNT_W'(1);
                    end
                    done_next  = 1'b1;
                    state_next = qrhc_pkg::ST_IDLE;
                end
                else
                begin
                    addr_next = addr_plus[qrhc_pkg::IDX_W-1:0];
                end
            end

            default:
            begin
                state_next = qrhc_pkg::ST_IDLE;
            end
        endcase
    end

    // The flags are updated at the same edge that raises done, so they carry
    // the result directly.
    assign busy        = (state_reg != qrhc_pkg::ST_IDLE);
    assign done        = done_reg;
    assign no_conflict = !conflict_reg;
    assign table_full  = overflow_reg;

endmodule

// ===== rtl/core/qrhc_checker.sv =====
// Port-level checker for the queue resource hazard checker, with its bind.
// Sees only the top-level ports. Uses qrhc_pkg for the mode codes.
module qrhc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  mode,
    input logic        done,
    input logic        no_conflict,
    input logic        table_full
);

    // A result is only shown once the scan has ended.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // An accepted request either finishes next cycle or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request vanished");

    // A clear request answers next cycle with a clean status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == qrhc_pkg::MODE_CLEAR)
        |=> (done && no_conflict && !table_full))
        else $error("clear request gave wrong result");

    // No result appears without a request in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!busy && !start) |=> !done)
        else $error("spurious result");

endmodule

bind queue_resource_hazard_checker_core qrhc_checker u_qrhc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .done        (done),
    .no_conflict (no_conflict),
    .table_full  (table_full)
);
